>>> hw/rtl/blst_pkg.sv
// Shared types and constants of the binned latency statistics table.
// Holds table geometry, the bucket bound list and the table entry layout.
// No dependencies.
package blst_pkg;

   localparam int NUM_STRATEGIES = 4;
   localparam int NUM_DIST_KINDS = 16;
   localparam int NUM_BUCKETS    = 41;

   localparam int BOUND_LIST_LEN = 41;
   localparam int USED_BOUNDS    = (NUM_BUCKETS < BOUND_LIST_LEN) ? NUM_BUCKETS : BOUND_LIST_LEN;
   localparam int STORE_DEPTH    = NUM_STRATEGIES * NUM_DIST_KINDS * NUM_BUCKETS;
   localparam int ADDR_W         = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int STRAT_W        = (NUM_STRATEGIES > 1) ? $clog2(NUM_STRATEGIES) : 1;
   localparam int KIND_W         = (NUM_DIST_KINDS > 1) ? $clog2(NUM_DIST_KINDS) : 1;

   localparam int STRATEGY_W = 2;
   localparam int DIST_W     = 4;
   localparam int LEN_W      = 32;
   localparam int TIME_W     = 64;
   localparam int BOUND_W    = 17;
   localparam int BKT_W      = 6;
   localparam int COUNT_W    = 32;
   localparam int TOTAL_W    = 64;
   localparam int LMS_W      = 32;

   localparam logic [LMS_W-1:0] LMS_RESET = 32'd100;

   typedef logic [BOUND_W-1:0] bound_type;

   localparam bound_type BOUND_LIST [BOUND_LIST_LEN] = '{
      17'd8,     17'd10,    17'd16,    17'd20,    17'd25,    17'd32,    17'd40,
      17'd50,    17'd64,    17'd80,    17'd100,   17'd128,   17'd160,   17'd200,
      17'd250,   17'd320,   17'd400,   17'd500,   17'd640,   17'd800,   17'd1000,
      17'd1280,  17'd1600,  17'd2000,  17'd2500,  17'd3200,  17'd4000,  17'd5000,
      17'd6400,  17'd8000,  17'd10000, 17'd12800, 17'd16000, 17'd20000, 17'd25000,
      17'd32000, 17'd40000, 17'd50000, 17'd64000, 17'd80000, 17'd100000
   };

   typedef struct packed {
      logic [COUNT_W-1:0] samples;
      logic [TIME_W-1:0]  time_sum;
      logic [TIME_W-1:0]  fastest;
      logic [TIME_W-1:0]  slowest;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{
      samples:  '0,
      time_sum: '0,
      fastest:  '1,
      slowest:  '0
   };

endpackage

>>> hw/rtl/binned_latency_stats_table.sv
// Top level of the binned latency statistics table.
// Bucket search, table memory with read-modify-write sequencer, global count.
// Depends on blst_pkg.

// Each item is one timing sample. Its batch length picks a bucket (smallest
// listed bound not below it, else the last bound), and the table entry for
// (strategy, kind, bucket) gets the time added to its saturating sum, its
// saturating count bumped, and its min and max updated. One result item per
// sample: rsp_strobe is high for exactly one cycle, registered after the item
// has passed through the READ and UPDATE states, and there is no way to hold
// it off - capture it then.
// busy is high from the accepting edge until the result cycle, so a new item
// can start in the strobe cycle, but none is taken while one is in flight: the
// single table memory reads the entry in READ and writes it back updated in UPDATE.
// After reset busy stays high while a clearing pass writes the reset value
// into every table entry, one entry a cycle; csr writes are taken at any time
// (csr_ready is tied high) but should only be issued while idle.
module binned_latency_stats_table (
   input  logic                          clock,
   input  logic                          reset,
   // sample input
   input  logic                          start,
   output logic                          busy,
   input  logic [blst_pkg::STRATEGY_W-1:0] req_strategy_id,
   input  logic [blst_pkg::DIST_W-1:0]   req_dist_kind,
   input  logic [blst_pkg::LEN_W-1:0]    req_batch_len,
   input  logic [blst_pkg::TIME_W-1:0]   req_elapsed_ns,
   // result
   output logic                          rsp_strobe,
   output logic [blst_pkg::BOUND_W-1:0]  rsp_bucket_bound,
   output logic [blst_pkg::BKT_W-1:0]    rsp_bucket_index,
   output logic [blst_pkg::COUNT_W-1:0]  rsp_entry_samples,
   output logic [blst_pkg::TIME_W-1:0]   rsp_entry_time_sum,
   output logic [blst_pkg::TIME_W-1:0]   rsp_entry_fastest,
   output logic [blst_pkg::TIME_W-1:0]   rsp_entry_slowest,
   output logic [blst_pkg::TOTAL_W-1:0]  rsp_global_samples,
   output logic                          rsp_enough_data,
   // learning_min_samples register
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [blst_pkg::LMS_W-1:0]    csr_wdata
);
   import blst_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UPDATE
   } state_type;

   // control state
   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [LMS_W-1:0]   lms_ff, lms_in;
   logic               strobe_ff, strobe_in;

   // item in flight (payload, no reset)
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [BKT_W-1:0]   bkt_ff, bkt_in;
   logic [TIME_W-1:0]  time_ff, time_in;

   // result registers (payload)
   logic [BOUND_W-1:0] out_bound_ff, out_bound_in;
   logic [BKT_W-1:0]   out_bkt_ff, out_bkt_in;
   entry_type          out_entry_ff, out_entry_in;
   logic [TOTAL_W-1:0] out_total_ff, out_total_in;
   logic               out_enough_ff, out_enough_in;

   // table memory: one read and one write port, registered read
   entry_type          mem [STORE_DEPTH];
   entry_type          rd_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   entry_type          mem_wdata;

   // front end: clamp indices, bucket search, entry address
   logic [STRAT_W-1:0] strat;
   logic [KIND_W-1:0]  kind;
   logic [BKT_W-1:0]   bkt;
   logic [31:0]        addr_full;

   always_comb begin
      if (32'(req_strategy_id) >= 32'(NUM_STRATEGIES)) begin
         strat = STRAT_W'(NUM_STRATEGIES - 1);
      end else begin
         strat = STRAT_W'(req_strategy_id);
      end
      if (32'(req_dist_kind) >= 32'(NUM_DIST_KINDS)) begin
         kind = KIND_W'(NUM_DIST_KINDS - 1);
      end else begin
         kind = KIND_W'(req_dist_kind);
      end
      // independent compares against the bound list, lowest match wins
      bkt = BKT_W'(USED_BOUNDS - 1);
      for (int k = USED_BOUNDS - 1; k >= 0; k--) begin
         if (32'(BOUND_LIST[k]) >= req_batch_len) begin
            bkt = BKT_W'(k);
         end
      end
      addr_full = (32'(strat) * 32'(NUM_DIST_KINDS) + 32'(kind)) * 32'(NUM_BUCKETS)
                  + 32'(bkt);
      if (addr_full >= 32'(STORE_DEPTH)) begin
         addr_full = 32'(STORE_DEPTH - 1);
      end
   end

   // entry update from the registered read
   logic [TIME_W:0]    sum_wide;
   entry_type          upd;
   logic [TOTAL_W-1:0] total_next;

   always_comb begin
      sum_wide = {1'b0, rd_ff.time_sum} + {1'b0, time_ff};
      upd.time_sum = sum_wide[TIME_W] ? '1 : sum_wide[TIME_W-1:0];
      upd.samples  = (rd_ff.samples == '1) ? rd_ff.samples : rd_ff.samples + 1'b1;
      upd.fastest  = (time_ff < rd_ff.fastest) ? time_ff : rd_ff.fastest;
      upd.slowest  = (time_ff > rd_ff.slowest) ? time_ff : rd_ff.slowest;
      total_next   = (total_ff == '1) ? total_ff : total_ff + 1'b1;
   end

   // memory write port: clearing pass or write-back
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = upd;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = ENTRY_RESET;
      end else if (state_ff == ST_UPDATE) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[addr_ff];
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      total_in      = total_ff;
      lms_in        = lms_ff;
      strobe_in     = 1'b0;
      addr_in       = addr_ff;
      bkt_in        = bkt_ff;
      time_in       = time_ff;
      out_bound_in  = out_bound_ff;
      out_bkt_in    = out_bkt_ff;
      out_entry_in  = out_entry_ff;
      out_total_in  = out_total_ff;
      out_enough_in = out_enough_ff;

      if (csr_valid) begin
         lms_in = csr_wdata;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (32'(clr_addr_ff) == 32'(STORE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               addr_in  = ADDR_W'(addr_full);
               bkt_in   = bkt;
               time_in  = req_elapsed_ns;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            total_in      = total_next;
            strobe_in     = 1'b1;
            out_bound_in  = BOUND_LIST[bkt_ff];
            out_bkt_in    = bkt_ff;
            out_entry_in  = upd;
            out_total_in  = total_next;
            out_enough_in = (total_next >= TOTAL_W'(lms_ff));
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         total_ff    <= '0;
         lms_ff      <= LMS_RESET;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         total_ff    <= total_in;
         lms_ff      <= lms_in;
         strobe_ff   <= strobe_in;
      end
      addr_ff       <= addr_in;
      bkt_ff        <= bkt_in;
      time_ff       <= time_in;
      out_bound_ff  <= out_bound_in;
      out_bkt_ff    <= out_bkt_in;
      out_entry_ff  <= out_entry_in;
      out_total_ff  <= out_total_in;
      out_enough_ff <= out_enough_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_strobe         = strobe_ff;
   assign rsp_bucket_bound   = out_bound_ff;
   assign rsp_bucket_index   = out_bkt_ff;
   assign rsp_entry_samples  = out_entry_ff.samples;
   assign rsp_entry_time_sum = out_entry_ff.time_sum;
   assign rsp_entry_fastest  = out_entry_ff.fastest;
   assign rsp_entry_slowest  = out_entry_ff.slowest;
   assign rsp_global_samples = out_total_ff;
   assign rsp_enough_data    = out_enough_ff;

endmodule

>>> verif/binned_latency_stats_table_tb.sv
// Self-checking testbench for binned_latency_stats_table.
// Drives timing samples and register writes, and checks each result against its own predictor.
// Depends on blst_pkg and the binned_latency_stats_table RTL.
module binned_latency_stats_table_tb;
   import blst_pkg::*;

   // Bucket bounds, kept here apart from the package so that a bad bound
   // list in the RTL cannot hide itself.
   localparam int N_LIMITS = 41;
   localparam logic [16:0] BKT_LIMITS [N_LIMITS] = '{
      17'd8,     17'd10,    17'd16,    17'd20,    17'd25,    17'd32,    17'd40,
      17'd50,    17'd64,    17'd80,    17'd100,   17'd128,   17'd160,   17'd200,
      17'd250,   17'd320,   17'd400,   17'd500,   17'd640,   17'd800,   17'd1000,
      17'd1280,  17'd1600,  17'd2000,  17'd2500,  17'd3200,  17'd4000,  17'd5000,
      17'd6400,  17'd8000,  17'd10000, 17'd12800, 17'd16000, 17'd20000, 17'd25000,
      17'd32000, 17'd40000, 17'd50000, 17'd64000, 17'd80000, 17'd100000
   };
   localparam int LIVE_LIMITS = (NUM_BUCKETS < N_LIMITS) ? NUM_BUCKETS : N_LIMITS;
   localparam int TABLE_SIZE  = NUM_STRATEGIES * NUM_DIST_KINDS * NUM_BUCKETS;
   localparam logic [31:0] LEARN_MIN_AT_RESET = 32'd100;
   // Idle cycles after the last result before the next register write.
   localparam int SETTLE_CYCLES = 6;

   // One pending sample plus the idle cycles to leave before it is offered.
   typedef struct {
      logic [STRATEGY_W-1:0] strategy;
      logic [DIST_W-1:0]     kind;
      logic [LEN_W-1:0]      len;
      logic [TIME_W-1:0]     ns;
      int                    gap;
   } sample_type;

   // What one result item is expected to carry.
   typedef struct {
      logic [BOUND_W-1:0] bound;
      logic [BKT_W-1:0]   index;
      logic [COUNT_W-1:0] samples;
      logic [TIME_W-1:0]  time_sum;
      logic [TIME_W-1:0]  fastest;
      logic [TIME_W-1:0]  slowest;
      logic [TOTAL_W-1:0] run_total;
      logic               enough;
   } entry_view_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [STRATEGY_W-1:0] req_strategy_id = '0;
   logic [DIST_W-1:0]     req_dist_kind = '0;
   logic [LEN_W-1:0]      req_batch_len = '0;
   logic [TIME_W-1:0]     req_elapsed_ns = '0;
   logic                  rsp_strobe;
   logic [BOUND_W-1:0]    rsp_bucket_bound;
   logic [BKT_W-1:0]      rsp_bucket_index;
   logic [COUNT_W-1:0]    rsp_entry_samples;
   logic [TIME_W-1:0]     rsp_entry_time_sum;
   logic [TIME_W-1:0]     rsp_entry_fastest;
   logic [TIME_W-1:0]     rsp_entry_slowest;
   logic [TOTAL_W-1:0]    rsp_global_samples;
   logic                  rsp_enough_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [LMS_W-1:0]      csr_wdata = '0;

   binned_latency_stats_table i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_strategy_id    (req_strategy_id),
      .req_dist_kind      (req_dist_kind),
      .req_batch_len      (req_batch_len),
      .req_elapsed_ns     (req_elapsed_ns),
      .rsp_strobe         (rsp_strobe),
      .rsp_bucket_bound   (rsp_bucket_bound),
      .rsp_bucket_index   (rsp_bucket_index),
      .rsp_entry_samples  (rsp_entry_samples),
      .rsp_entry_time_sum (rsp_entry_time_sum),
      .rsp_entry_fastest  (rsp_entry_fastest),
      .rsp_entry_slowest  (rsp_entry_slowest),
      .rsp_global_samples (rsp_global_samples),
      .rsp_enough_data    (rsp_enough_data),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Shadow copy of the statistics table and the learning register
   // ---------------------------------------------------------------
   logic [TIME_W-1:0]  sum_shadow   [TABLE_SIZE];
   logic [COUNT_W-1:0] count_shadow [TABLE_SIZE];
   logic [TIME_W-1:0]  min_shadow   [TABLE_SIZE];
   logic [TIME_W-1:0]  max_shadow   [TABLE_SIZE];
   logic [TOTAL_W-1:0] samples_seen_shadow;
   logic [LMS_W-1:0]   learn_min_shadow;

   sample_type     sample_backlog [$];   // items waiting to be offered
   entry_view_type stats_due      [$];   // results predicted, not yet seen

   int mismatches    = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int settings_used = 0;

   // Smallest live bound not below the length, else the last live bound.
   function automatic int bucket_of(input logic [LEN_W-1:0] len);
      for (int k = 0; k < LIVE_LIMITS; k++)
         if ({15'd0, BKT_LIMITS[k]} >= len) return k;
      return LIVE_LIMITS - 1;
   endfunction

   // Applies one accepted sample to the shadow table and queues the result.
   task automatic record_sample(input logic [STRATEGY_W-1:0] s_in,
                                input logic [DIST_W-1:0] k_in,
                                input logic [LEN_W-1:0] len,
                                input logic [TIME_W-1:0] ns);
      int             s;
      int             k;
      int             b;
      int             addr;
      logic [64:0]    acc;
      entry_view_type e;
      s = int'(s_in);
      k = int'(k_in);
      // out-of-range ids clamp to the top row; unreachable at the default
      // geometry, but kept so the predictor follows the parameters
      if (s >= NUM_STRATEGIES) s = NUM_STRATEGIES - 1;
      if (k >= NUM_DIST_KINDS) k = NUM_DIST_KINDS - 1;
      b = bucket_of(len);
      addr = (s * NUM_DIST_KINDS + k) * NUM_BUCKETS + b;
      if (addr >= TABLE_SIZE) addr = TABLE_SIZE - 1;

      acc = {1'b0, sum_shadow[addr]} + {1'b0, ns};
      sum_shadow[addr] = acc[64] ? '1 : acc[63:0];
      if (count_shadow[addr] != '1) count_shadow[addr] = count_shadow[addr] + 1'b1;
      if (ns < min_shadow[addr]) min_shadow[addr] = ns;
      if (ns > max_shadow[addr]) max_shadow[addr] = ns;
      if (samples_seen_shadow != '1) samples_seen_shadow = samples_seen_shadow + 1'b1;

      e.bound     = BKT_LIMITS[b];
      e.index     = b[BKT_W-1:0];
      e.samples   = count_shadow[addr];
      e.time_sum  = sum_shadow[addr];
      e.fastest   = min_shadow[addr];
      e.slowest   = max_shadow[addr];
      e.run_total = samples_seen_shadow;
      e.enough    = (samples_seen_shadow >= {32'd0, learn_min_shadow});
      stats_due.push_back(e);
      items_sent++;
   endtask

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("[%0t] mismatch: %s got %0h want %0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic check_field(input string what, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) flag_mismatch(what, got, want);
   endtask

   // ---------------------------------------------------------------
   // Driver: offers backlog items on start, honoring each item's gap.
   // start stays high straight into the next item when its gap is zero,
   // so back-to-back acceptance at the strobe cycle gets exercised.
   // ---------------------------------------------------------------
   int         idle_run = 0;
   sample_type next_item;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         idle_run = 0;
      end else if (!start || !busy) begin
         if (start)
            record_sample(req_strategy_id, req_dist_kind, req_batch_len, req_elapsed_ns);
         if (sample_backlog.size() != 0 && idle_run >= sample_backlog[0].gap) begin
            next_item = sample_backlog.pop_front();
            req_strategy_id <= next_item.strategy;
            req_dist_kind   <= next_item.kind;
            req_batch_len   <= next_item.len;
            req_elapsed_ns  <= next_item.ns;
            start           <= 1'b1;
            idle_run = 0;
         end else begin
            // idle: payload is junk that the block must ignore
            start           <= 1'b0;
            req_strategy_id <= STRATEGY_W'($urandom);
            req_dist_kind   <= DIST_W'($urandom);
            req_batch_len   <= $urandom;
            req_elapsed_ns  <= {$urandom, $urandom};
            if (sample_backlog.size() != 0) idle_run++;
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: every strobe is one result item, matched to the oldest
   // prediction. Outputs are sampled at the edge that ends the cycle.
   // ---------------------------------------------------------------
   entry_view_type want_entry;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (stats_due.size() == 0) begin
            flag_mismatch("result with nothing due", rsp_global_samples, 64'd0);
         end else begin
            want_entry = stats_due.pop_front();
            check_field("bucket_bound",   64'(rsp_bucket_bound),   64'(want_entry.bound));
            check_field("bucket_index",   64'(rsp_bucket_index),   64'(want_entry.index));
            check_field("entry_samples",  64'(rsp_entry_samples),  64'(want_entry.samples));
            check_field("entry_time_sum", rsp_entry_time_sum, want_entry.time_sum);
            check_field("entry_fastest",  rsp_entry_fastest,  want_entry.fastest);
            check_field("entry_slowest",  rsp_entry_slowest,  want_entry.slowest);
            check_field("global_samples", rsp_global_samples, want_entry.run_total);
            check_field("enough_data",    64'(rsp_enough_data),    64'(want_entry.enough));
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   int calm_left = 0;   // items left in the current gap stretch
   bit calm_mode = 0;   // 1: stretch runs with no idle cycles

   function int draw_gap();
      if (calm_left == 0) begin
         calm_left = $urandom_range(5, 40);
         calm_mode = ($urandom_range(0, 99) < 30);
      end
      calm_left--;
      return calm_mode ? 0 : $urandom_range(0, 13);
   endfunction

   task automatic queue_sample(input logic [STRATEGY_W-1:0] s, input logic [DIST_W-1:0] k,
                               input logic [LEN_W-1:0] len, input logic [TIME_W-1:0] ns);
      sample_type it;
      it.strategy = s;
      it.kind     = k;
      it.len      = len;
      it.ns       = ns;
      it.gap      = draw_gap();
      sample_backlog.push_back(it);
   endtask

   // Random sample biased toward a few hot entries so that min, max and
   // sums get updated many times; the rest spreads over the whole table.
   task automatic queue_random_sample();
      logic [DIST_W-1:0] k;
      logic [LEN_W-1:0]  len;
      logic [TIME_W-1:0] ns;
      int                pick;
      int                hot_kinds [3];
      hot_kinds = '{0, 5, 15};
      k = DIST_W'(($urandom_range(0, 99) < 60) ? hot_kinds[$urandom_range(0, 2)]
                                               : $urandom_range(0, 15));

      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2, 3: len = BKT_LIMITS[$urandom_range(0, 4)] + $urandom_range(0, 2) - 1;
         4, 5:       len = $urandom_range(0, 120);
         6:          len = $urandom_range(0, 100001);
         7:          len = $urandom;
         8:          len = 32'd100000 + $urandom_range(0, 2);
         default:    len = BKT_LIMITS[$urandom_range(0, N_LIMITS - 1)] + $urandom_range(0, 2) - 1;
      endcase

      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2, 3, 4: ns = TIME_W'($urandom_range(0, 5000));
         5, 6:          ns = {$urandom, $urandom};
         7:             ns = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);  // sum saturation
         8:             ns = '0;
         default:       ns = {$urandom_range(0, 15), $urandom};
      endcase
      queue_sample(STRATEGY_W'($urandom_range(0, 3)), k, len, ns);
   endtask

   // Returns once nothing is pending, offered, in flight or predicted.
   // Checked on the falling edge, clear of the clocked blocks.
   task automatic wait_quiet();
      @(negedge clock);
      while (sample_backlog.size() != 0 || start || busy || stats_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes learning_min_samples over the csr channel, only while idle.
   task automatic set_learning_min(input logic [LMS_W-1:0] value);
      wait_quiet();
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      learn_min_shadow = value;
      settings_used++;
      csr_valid <= 1'b0;
      csr_wdata <= $urandom;
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
         sum_shadow[i]   = '0;
         count_shadow[i] = '0;
         min_shadow[i]   = '1;
         max_shadow[i]   = '0;
      end
      samples_seen_shadow = '0;
      learn_min_shadow    = LEARN_MIN_AT_RESET;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed items, checked against the reset value of the register.
      // Busy covers the clearing pass, so the driver simply waits it out.
      @(negedge clock);
      queue_sample(2'd0, 4'd0,  32'd0,          64'd0);
      queue_sample(2'd0, 4'd0,  32'd0,          64'hFFFF_FFFF_FFFF_FFFF);
      queue_sample(2'd0, 4'd0,  32'd8,          64'd1);          // sum stays saturated
      queue_sample(2'd1, 4'd1,  32'd9,          64'd100);
      queue_sample(2'd1, 4'd1,  32'd10,         64'd50);         // new minimum
      queue_sample(2'd1, 4'd1,  32'd10,         64'd200);        // new maximum
      queue_sample(2'd2, 4'd7,  32'd100000,     64'd12345);
      queue_sample(2'd2, 4'd7,  32'd100001,     64'd777);        // above all bounds
      queue_sample(2'd3, 4'd15, 32'hFFFF_FFFF,  64'h8000_0000_0000_0000);
      queue_sample(2'd3, 4'd15, 32'h8000_0000,  64'h7FFF_FFFF_FFFF_FFFF);
      queue_sample(2'd3, 4'd15, 32'd1,          64'h5555_AAAA_5555_AAAA);
      queue_sample(2'd2, 4'd10, 32'd99999,      64'hAAAA_5555_AAAA_5555);
      // every seventh bound exactly and one past it, walking the rows
      for (int b = 0; b < N_LIMITS; b += 7) begin
         queue_sample(STRATEGY_W'(b % 4), DIST_W'(b % 16), LEN_W'(BKT_LIMITS[b]),
                      TIME_W'($urandom_range(0, 999)));
         queue_sample(STRATEGY_W'(b % 4), DIST_W'(b % 16), LEN_W'(BKT_LIMITS[b]) + 1'b1,
                      TIME_W'($urandom_range(0, 999)));
      end

      // Random phases, each under its own learning minimum. Two of them put
      // the threshold just ahead of the running total so the flag flips.
      wait_quiet();
      set_learning_min(samples_seen_shadow[31:0] + 32'd30);
      @(negedge clock);
      repeat (450) queue_random_sample();

      set_learning_min(32'd0);
      @(negedge clock);
      repeat (400) queue_random_sample();

      set_learning_min(32'hFFFF_FFFF);
      @(negedge clock);
      repeat (400) queue_random_sample();

      wait_quiet();
      set_learning_min(samples_seen_shadow[31:0] + 32'd200);
      @(negedge clock);
      repeat (500) queue_random_sample();

      wait_quiet();
      if (stats_due.size() != 0)
         flag_mismatch("results never seen", 64'(stats_due.size()), 64'd0);

      $display("Recorded %0d samples and checked %0d results across %0d register settings",
               items_sent, results_seen, settings_used + 1);
      $display("Mismatches reported: %0d", mismatches);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run (clearing pass plus every
   // item at its longest gap and full turnaround through the read and update states).
   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/blst_pkg.sv
hw/rtl/binned_latency_stats_table.sv
verif/binned_latency_stats_table_tb.sv
